// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define KHTE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define KHTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/khte_pkg.sv
// ---------------------------------------------------------------------------
// khte_pkg
// Types and constants of the keyed hash table engine.
// ---------------------------------------------------------------------------
package khte_pkg;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;
  localparam int APB_W    = 32;
  localparam int ADDR_W   = 2;

  localparam logic [31:0] HASH_MULT = 32'h9e37_0001;

  // Register offsets on the configuration port.
  localparam logic [ADDR_W-1:0] REG_HASH_ORDER = 2'd0;

  localparam int ORDER_RESET = 8;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul;
    logic hash;
    logic read;
    logic exec;
    logic clr_start;
    logic clr_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic out_busy;
  } sts_t;

endpackage

// File: rtl/khte_ctrl.sv
// ---------------------------------------------------------------------------
// khte_ctrl
// Sequencer for the table engine: clearing sweep, then multiply, hash,
// bucket read and execute for each word.
// ---------------------------------------------------------------------------
module khte_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr,
  input  logic            req_valid,
  output logic            req_stall,
  input  khte_pkg::sts_t  sts,
  output khte_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_HASH  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EXEC  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       take;
  logic       accept;

  // A word can enter when idle, or when the current one retires this cycle.
  assign take      = (state == S_IDLE) || ((state == S_EXEC) && !sts.out_busy);
  assign req_stall = !take || cfg_wr;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load_in   = accept;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_HASH;
      end
      S_HASH: begin
        cmd.hash   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = accept ? S_MUL : S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (cfg_wr) begin
      cmd.clr_start = 1'b1;
      cmd.clr_step  = 1'b0;
      state_next    = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/khte_dpath.sv
// ---------------------------------------------------------------------------
// khte_dpath
// Hash multiplier, bucket row memories, way compare, result register and
// the hash_order register.
// ---------------------------------------------------------------------------
module khte_dpath #(
  parameter int MAX_ORDER = 8,
  parameter int WAYS      = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  khte_pkg::cmd_t                 cmd,
  output khte_pkg::sts_t                 sts,
  input  logic                           cfg_wr,
  input  logic [khte_pkg::CFG_W-1:0]     cfg_data,
  output logic [khte_pkg::APB_W-1:0]     prdata,
  input  logic [khte_pkg::FUNC_W-1:0]    func,
  input  logic [khte_pkg::KEY_W-1:0]     key,
  input  logic [khte_pkg::HANDLE_W-1:0]  item_handle,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [khte_pkg::STATUS_W-1:0]  status,
  output logic [khte_pkg::HANDLE_W-1:0]  found_handle
);

  localparam int BUCKETS   = 1 << MAX_ORDER;
  localparam int ORDER_W   = $clog2(MAX_ORDER + 1);
  localparam int ORDER_RST = (khte_pkg::ORDER_RESET > MAX_ORDER) ? MAX_ORDER
                                                                : khte_pkg::ORDER_RESET;

  typedef khte_pkg::entry_t [WAYS-1:0] row_t;

  // Configuration register.
  logic [ORDER_W-1:0] hash_order;
  logic [ORDER_W-1:0] order_next;

  always_comb begin
    if (cfg_data == '0) begin
      order_next = ORDER_W'(1);
    end else if (int'(cfg_data) > MAX_ORDER) begin
      order_next = ORDER_W'(MAX_ORDER);
    end else begin
      order_next = ORDER_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_order <= ORDER_W'(ORDER_RST);
    end else if (cfg_wr) begin
      hash_order <= order_next;
    end
  end

  assign prdata = khte_pkg::APB_W'(hash_order);

  // Captured request word.
  logic [khte_pkg::FUNC_W-1:0]   func_r;
  logic [khte_pkg::KEY_W-1:0]    key_r;
  logic [khte_pkg::HANDLE_W-1:0] handle_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= func;
      key_r    <= key;
      handle_r <= item_handle;
    end
  end

  // The 64x32 hash product is split into two 32x32 partial products; only
  // the low half of the upper one survives the modulo.
  logic [63:0] p_lo_c;
  logic [31:0] p_hi_c;
  logic [63:0] p_lo;
  logic [31:0] p_hi;

  assign p_lo_c = key_r[31:0] * khte_pkg::HASH_MULT;
  assign p_hi_c = key_r[63:32] * khte_pkg::HASH_MULT;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_lo <= p_lo_c;
      p_hi <= p_hi_c;
    end
  end

  logic [63:0]          hash_c;
  logic [MAX_ORDER-1:0] hash_top;
  logic [ORDER_W-1:0]   shamt;
  logic [MAX_ORDER-1:0] bucket_r;

  assign hash_c   = p_lo + {p_hi, 32'b0};
  assign hash_top = hash_c[63 -: MAX_ORDER];
  assign shamt    = ORDER_W'(MAX_ORDER) - hash_order;

  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      bucket_r <= hash_top >> shamt;
    end
  end

  // Bucket rows: keys and handles, and a separate row of way valid bits.
  row_t            row_mem [BUCKETS];
  logic [WAYS-1:0] vld_mem [BUCKETS];
  row_t            row_q;
  logic [WAYS-1:0] vld_q;

  logic                 row_we;
  row_t                 row_new;
  logic                 vld_we;
  logic [WAYS-1:0]      vld_new;
  logic [MAX_ORDER-1:0] vld_waddr;
  logic [WAYS-1:0]      vld_wdata;
  logic [MAX_ORDER-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      row_q <= row_mem[bucket_r];
    end
    if (row_we) begin
      row_mem[bucket_r] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      vld_q <= vld_mem[bucket_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step || vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
  end

  assign vld_waddr = cmd.clr_step ? clr_cnt : bucket_r;
  assign vld_wdata = cmd.clr_step ? '0 : vld_new;

  // Clearing sweep over every row of valid bits.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // The controller only looks at this while it sweeps.
  assign sts.clr_done = (clr_cnt == '1);

  // Way compare and update. Keys are unique within a bucket, so at most one
  // way hits and the handle can be gathered with an OR.
  logic [WAYS-1:0]               hit;
  logic [WAYS-1:0]               free;
  logic [WAYS-1:0]               free_oh;
  logic [khte_pkg::HANDLE_W-1:0] hit_handle;
  logic [khte_pkg::STATUS_W-1:0] status_c;
  logic [khte_pkg::HANDLE_W-1:0] found_c;
  logic                          ins_ok;
  logic                          rem_ok;

  always_comb begin
    hit_handle = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = vld_q[w] && (row_q[w].key == key_r);
      if (hit[w]) begin
        hit_handle = hit_handle | row_q[w].handle;
      end
    end
  end

  assign free    = ~vld_q;
  assign free_oh = free & (~free + WAYS'(1));

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_new[w] = free_oh[w] ? khte_pkg::entry_t'{key: key_r, handle: handle_r}
                              : row_q[w];
    end
  end

  always_comb begin
    status_c = khte_pkg::ST_MISS;
    found_c  = '0;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    case (func_r)
      khte_pkg::FUNC_INSERT: begin
        if (|hit) begin
          status_c = khte_pkg::ST_DUP;
        end else if (free == '0) begin
          status_c = khte_pkg::ST_FULL;
        end else begin
          status_c = khte_pkg::ST_OK;
          ins_ok   = 1'b1;
        end
      end
      khte_pkg::FUNC_FIND: begin
        if (|hit) begin
          status_c = khte_pkg::ST_OK;
          found_c  = hit_handle;
        end
      end
      khte_pkg::FUNC_REMOVE: begin
        if (|hit) begin
          status_c = khte_pkg::ST_OK;
          found_c  = hit_handle;
          rem_ok   = 1'b1;
        end
      end
      default: begin
        status_c = khte_pkg::ST_MISS;
      end
    endcase
  end

  assign row_we  = cmd.exec && ins_ok;
  assign vld_we  = cmd.exec && (ins_ok || rem_ok);
  assign vld_new = ins_ok ? (vld_q | free_oh) : (vld_q & ~hit);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= status_c;
      found_handle <= found_c;
    end
  end

  assign sts.out_busy = rsp_valid && rsp_stall;

endmodule

// File: rtl/keyed_hash_table_engine.sv
// ---------------------------------------------------------------------------
// keyed_hash_table_engine
// Table of unique 64-bit keys with 32-bit handles in WAYS-way buckets.
// ---------------------------------------------------------------------------
// An accepted request word steps through the multiply, hash, bucket read
// and execute states before its response word is registered. A new word
// is taken only while idle or as the current word retires from execute.
// Reset, and every hash_order write, start a clearing sweep over all
// 2^MAX_ORDER valid rows; requests are stalled until it finishes.
module keyed_hash_table_engine #(
  parameter int MAX_ORDER = 8,
  parameter int WAYS      = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [khte_pkg::ADDR_W-1:0]    paddr,
  input  logic [khte_pkg::APB_W-1:0]     pwdata,
  output logic [khte_pkg::APB_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [khte_pkg::FUNC_W-1:0]    func,
  input  logic [khte_pkg::KEY_W-1:0]     key,
  input  logic [khte_pkg::HANDLE_W-1:0]  item_handle,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [khte_pkg::STATUS_W-1:0]  status,
  output logic [khte_pkg::HANDLE_W-1:0]  found_handle
);

  khte_pkg::cmd_t cmd;
  khte_pkg::sts_t sts;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == khte_pkg::REG_HASH_ORDER);

  khte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  khte_dpath #(
    .MAX_ORDER (MAX_ORDER),
    .WAYS      (WAYS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr       (cfg_wr),
    .cfg_data     (pwdata[khte_pkg::CFG_W-1:0]),
    .prdata       (prdata),
    .func         (func),
    .key          (key),
    .item_handle  (item_handle),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .found_handle (found_handle)
  );

endmodule

// File: rtl/khte_checker.sv
// ---------------------------------------------------------------------------
// khte_checker
// Port-level checks of the table engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module khte_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [khte_pkg::ADDR_W-1:0]    paddr,
  input logic [khte_pkg::APB_W-1:0]     prdata,
  input logic                           pready,
  input logic                           req_valid,
  input logic                           req_stall,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input logic [khte_pkg::STATUS_W-1:0]  status,
  input logic [khte_pkg::HANDLE_W-1:0]  found_handle
);

  logic order_wr;
  logic req_take;

  assign order_wr = psel && penable && pwrite && pready &&
                    (paddr == khte_pkg::REG_HASH_ORDER);
  assign req_take = req_valid && !req_stall;

  // A stalled response word holds its contents.
  `KHTE_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(found_handle), "response word changed while stalled")

  // Only a successful operation reports a handle.
  `KHTE_ASSERT_SAME(a_handle_zero, clk, rst, rsp_valid && (status != khte_pkg::ST_OK), found_handle == '0, "nonzero handle on a failed operation")

  // A hash_order write starts the clearing sweep, which stalls requests.
  `KHTE_ASSERT_NEXT(a_clear_stall, clk, rst, order_wr, req_stall, "request taken during the clearing sweep")

  // One word at a time: the cycle after an accept is stalled.
  `KHTE_ASSERT_NEXT(a_one_word, clk, rst, req_take, req_stall, "second request taken while one is in flight")

  // The stored order is clamped to at least one.
  `KHTE_ASSERT_NEXT(a_order_min, clk, rst, order_wr, prdata != '0, "hash_order read back as zero")

endmodule

bind keyed_hash_table_engine khte_checker u_khte_checker (.*);

// File: tb/sv/tb_keyed_hash_table_engine.sv
// ----------------------------------------------------------------------------
// tb_keyed_hash_table_engine
// Self-checking bench for the keyed hash table engine.
//
// A scoreboard class keeps its own copy of the bucket table and predicts the
// status and handle of every accepted request word. Each accepted response
// word is compared with the oldest prediction. The stimulus begins with
// directed cases: key and handle extremes, duplicates, misses, a full bucket
// and the unused function code. It then runs random phases over several
// table orders. Those phases hammer a few chosen buckets so that inserts,
// duplicates, overflows and removes keep meeting each other.
// ----------------------------------------------------------------------------
module tb_keyed_hash_table_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ORDER = 8;
  localparam int WAYS = 4;
  localparam int BUCKETS = 1 << MAX_ORDER;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PCT = 27;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 130;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [khte_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [khte_pkg::KEY_W-1:0] HASH_MULT64 = 64'(khte_pkg::HASH_MULT);

  typedef struct packed {
    logic [khte_pkg::STATUS_W-1:0] status;
    logic [khte_pkg::HANDLE_W-1:0] handle;
  } lookup_result_t;

  class hash_table_scoreboard;
    bit [khte_pkg::KEY_W-1:0] slot_key [SLOTS];
    bit [khte_pkg::HANDLE_W-1:0] slot_handle [SLOTS];
    bit slot_valid [SLOTS];
    int unsigned order;
    lookup_result_t expected_q[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned status_seen [4];

    function new();
      order = khte_pkg::ORDER_RESET;
      errors = 0;
      requests = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Out-of-range orders are clamped, and any write empties the table.
    function void set_order(bit [khte_pkg::CFG_W-1:0] v);
      if (v < 1) order = 1;
      else if (v > MAX_ORDER) order = MAX_ORDER;
      else order = v;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function int unsigned bucket_of(bit [khte_pkg::KEY_W-1:0] k);
      bit [khte_pkg::KEY_W-1:0] h;
      bit [khte_pkg::KEY_W-1:0] top;
      h = k * HASH_MULT64;
      top = h >> (khte_pkg::KEY_W - order);
      return int'(top[MAX_ORDER-1:0]);
    endfunction

    function void note_request(logic [khte_pkg::FUNC_W-1:0] f,
                               logic [khte_pkg::KEY_W-1:0] k,
                               logic [khte_pkg::HANDLE_W-1:0] h);
      int unsigned b;
      int hit_way;
      int free_way;
      int s;
      lookup_result_t r;
      b = bucket_of(k);
      hit_way = -1;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
        s = b * WAYS + w;
        if (slot_valid[s] && slot_key[s] == k && hit_way < 0) hit_way = w;
        if (!slot_valid[s] && free_way < 0) free_way = w;
      end
      r.status = khte_pkg::ST_MISS;
      r.handle = '0;
      case (f)
        khte_pkg::FUNC_INSERT: begin
          // A present key wins over a full bucket.
          if (hit_way >= 0) begin
            r.status = khte_pkg::ST_DUP;
          end else if (free_way < 0) begin
            r.status = khte_pkg::ST_FULL;
          end else begin
            s = b * WAYS + free_way;
            slot_valid[s] = 1'b1;
            slot_key[s] = k;
            slot_handle[s] = h;
            r.status = khte_pkg::ST_OK;
          end
        end
        khte_pkg::FUNC_FIND, khte_pkg::FUNC_REMOVE: begin
          if (hit_way >= 0) begin
            s = b * WAYS + hit_way;
            r.status = khte_pkg::ST_OK;
            r.handle = slot_handle[s];
            if (f == khte_pkg::FUNC_REMOVE) slot_valid[s] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      requests++;
      expected_q.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_response(logic [khte_pkg::STATUS_W-1:0] st,
                        logic [khte_pkg::HANDLE_W-1:0] h);
      lookup_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("response word with nothing pending (status %0d, handle %h)",
                         st, h));
        return;
      end
      want = expected_q.pop_front();
      status_seen[want.status]++;
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (h !== want.handle)
        report($sformatf("found_handle %h, expected %h", h, want.handle));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [khte_pkg::ADDR_W-1:0] paddr = '0;
  logic [khte_pkg::APB_W-1:0] pwdata = '0;
  logic [khte_pkg::APB_W-1:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [khte_pkg::FUNC_W-1:0] func = '0;
  logic [khte_pkg::KEY_W-1:0] key = '0;
  logic [khte_pkg::HANDLE_W-1:0] item_handle = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [khte_pkg::STATUS_W-1:0] status;
  logic [khte_pkg::HANDLE_W-1:0] found_handle;

  hash_table_scoreboard sb;
  logic [khte_pkg::KEY_W-1:0] mult_inv;
  logic [khte_pkg::KEY_W-1:0] key_pool[$];
  bit quiet = 1'b0;
  int unsigned stuck_cycles = 0;
  int unsigned orders_run = 1;

  keyed_hash_table_engine #(
    .MAX_ORDER(MAX_ORDER),
    .WAYS(WAYS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .func(func),
    .key(key),
    .item_handle(item_handle),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .found_handle(found_handle)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(func, key, item_handle);
      if (rsp_valid && !rsp_stall) sb.check_response(status, found_handle);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (psel && penable && pready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] Watchdog: no word moved for %0d cycles", $time, stuck_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Multiplicative inverse modulo 2^64 by Newton iteration; each step doubles
  // the number of correct low bits.
  function automatic logic [khte_pkg::KEY_W-1:0] odd_inverse(
      logic [khte_pkg::KEY_W-1:0] a);
    logic [khte_pkg::KEY_W-1:0] x;
    x = a;
    repeat (6) x = x * (64'd2 - a * x);
    return x;
  endfunction

  // Picks a random hash whose top bits name the bucket, then maps it back.
  function automatic logic [khte_pkg::KEY_W-1:0] key_for_bucket(int unsigned b,
                                                                int unsigned ord);
    logic [khte_pkg::KEY_W-1:0] h;
    logic [khte_pkg::KEY_W-1:0] top;
    h = {$urandom(), $urandom()};
    top = 64'(b);
    h = (h & ({khte_pkg::KEY_W{1'b1}} >> ord)) | (top << (khte_pkg::KEY_W - ord));
    return h * mult_inv;
  endfunction

  task automatic send_req(input logic [khte_pkg::FUNC_W-1:0] f,
                          input logic [khte_pkg::KEY_W-1:0] k,
                          input logic [khte_pkg::HANDLE_W-1:0] h);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(99) < IDLE_PCT);
    end
    req_valid <= 1'b1;
    func <= f;
    key <= k;
    item_handle <= h;
    do @(posedge clk); while (req_stall);
  endtask

  // The extra edge first lets the monitor log the last accepted word.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_hash_order(input logic [khte_pkg::CFG_W-1:0] v);
    logic [khte_pkg::APB_W-1:0] wdata;
    wdata = $urandom();
    wdata[khte_pkg::CFG_W-1:0] = v;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= khte_pkg::REG_HASH_ORDER;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_order(v);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[khte_pkg::CFG_W-1:0] !== sb.order[khte_pkg::CFG_W-1:0])
      sb.report($sformatf("hash_order reads %0d, expected %0d",
                          prdata[khte_pkg::CFG_W-1:0], sb.order));
    psel <= 1'b0;
    penable <= 1'b0;
    orders_run++;
  endtask

  task automatic run_directed();
    logic [khte_pkg::KEY_W-1:0] dk [5];
    logic [khte_pkg::KEY_W-1:0] ones;
    ones = {khte_pkg::KEY_W{1'b1}};
    foreach (dk[i]) dk[i] = key_for_bucket(5, sb.order);
    send_req(khte_pkg::FUNC_INSERT, '0, {khte_pkg::HANDLE_W{1'b1}});
    send_req(khte_pkg::FUNC_INSERT, ones, '0);
    send_req(khte_pkg::FUNC_FIND, '0, $urandom());
    send_req(khte_pkg::FUNC_FIND, ones, $urandom());
    send_req(khte_pkg::FUNC_INSERT, '0, 32'h1234_5678);
    send_req(khte_pkg::FUNC_REMOVE, '0, $urandom());
    send_req(khte_pkg::FUNC_REMOVE, '0, $urandom());
    send_req(khte_pkg::FUNC_FIND, '0, $urandom());
    // The unused code must leave the table alone.
    send_req(FUNC_UNUSED, ones, $urandom());
    send_req(khte_pkg::FUNC_FIND, ones, $urandom());
    for (int i = 0; i < 4; i++) send_req(khte_pkg::FUNC_INSERT, dk[i], $urandom());
    send_req(khte_pkg::FUNC_INSERT, dk[4], $urandom());
    send_req(khte_pkg::FUNC_INSERT, dk[1], $urandom());
    send_req(khte_pkg::FUNC_REMOVE, dk[1], $urandom());
    send_req(khte_pkg::FUNC_INSERT, dk[4], {khte_pkg::HANDLE_W{1'b1}});
    send_req(khte_pkg::FUNC_FIND, dk[4], $urandom());
    send_req(khte_pkg::FUNC_FIND, dk[1], $urandom());
    send_req(khte_pkg::FUNC_REMOVE, dk[4], $urandom());
    send_req(khte_pkg::FUNC_REMOVE, ones, $urandom());
  endtask

  task automatic run_random(input int n);
    int unsigned hot;
    int unsigned b;
    int unsigned r;
    logic [khte_pkg::FUNC_W-1:0] f;
    logic [khte_pkg::KEY_W-1:0] k;
    logic [khte_pkg::HANDLE_W-1:0] h;
    key_pool.delete();
    hot = (sb.order == 1) ? 2 : 3;
    for (int i = 0; i < hot; i++) begin
      b = $urandom_range((1 << sb.order) - 1);
      for (int j = 0; j < 6; j++) key_pool.push_back(key_for_bucket(b, sb.order));
    end
    for (int j = 0; j < 3; j++) key_pool.push_back({$urandom(), $urandom()});
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 5) f = FUNC_UNUSED;
      else if (r < 50) f = khte_pkg::FUNC_INSERT;
      else if (r < 75) f = khte_pkg::FUNC_FIND;
      else f = khte_pkg::FUNC_REMOVE;
      if ($urandom_range(99) < 85) k = key_pool[$urandom_range(key_pool.size() - 1)];
      else k = {$urandom(), $urandom()};
      r = $urandom_range(99);
      if (r < 10) h = '0;
      else if (r < 20) h = {khte_pkg::HANDLE_W{1'b1}};
      else h = $urandom();
      send_req(f, k, h);
    end
  endtask

  initial begin
    logic [khte_pkg::CFG_W-1:0] order_writes [5];
    order_writes = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd8};
    sb = new();
    mult_inv = odd_inverse(HASH_MULT64);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(PHASE_ITEMS);
    foreach (order_writes[p]) begin
      wait_drained();
      write_hash_order(order_writes[p]);
      // One whole phase runs with neither side idling.
      quiet <= (p == 2);
      run_random(PHASE_ITEMS);
    end
    wait_drained();
    $display("Ran %0d request words across %0d table orders.", sb.requests, orders_run);
    $display("Outcomes: %0d ok, %0d duplicate, %0d not found, %0d bucket full.",
             sb.status_seen[khte_pkg::ST_OK], sb.status_seen[khte_pkg::ST_DUP],
             sb.status_seen[khte_pkg::ST_MISS], sb.status_seen[khte_pkg::ST_FULL]);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/khte_pkg.sv
rtl/khte_ctrl.sv
rtl/khte_dpath.sv
rtl/keyed_hash_table_engine.sv
rtl/khte_checker.sv
tb/sv/tb_keyed_hash_table_engine.sv
